// ===== sv/sc2a_pkg.sv =====
`default_nettype none
package sc2a_pkg;

    localparam logic       REL_BIT     = 1'b1;
    localparam logic [6:0] LSHIFT_CODE = 7'h2A;
    localparam logic [6:0] RSHIFT_CODE = 7'h36;
    localparam logic [6:0] CAPS_CODE   = 7'h3A;
    localparam logic [6:0] FILL_MAX    = 7'h7F;
    localparam logic [6:0] CASE_BIT    = 7'h20;

    localparam logic       REQ_SCAN    = 1'b0;
    localparam logic       REQ_READ    = 1'b1;

    localparam logic [0:0] REG_ENABLE  = 1'b0;

    typedef enum logic [1:0] {
        K_NOP,
        K_READ,
        K_PUSH
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] ch;
    } t_cmd;

    typedef struct packed {
        logic       read_valid;
        logic [6:0] char_out;
        logic       overflow_dropped;
        logic [6:0] fill_count;
    } t_res;

    // returns {shifted, plain}
    function automatic logic [13:0] key_rom(input logic [6:0] code);
        logic [13:0] r;
        case (code)
            7'd1:  r = {7'h1B, 7'h1B};
            7'd2:  r = {7'h21, 7'h31};
            7'd3:  r = {7'h40, 7'h32};
            7'd4:  r = {7'h23, 7'h33};
            7'd5:  r = {7'h24, 7'h34};
            7'd6:  r = {7'h25, 7'h35};
            7'd7:  r = {7'h5E, 7'h36};
            7'd8:  r = {7'h26, 7'h37};
            7'd9:  r = {7'h2A, 7'h38};
            7'd10: r = {7'h28, 7'h39};
            7'd11: r = {7'h29, 7'h30};
            7'd12: r = {7'h5F, 7'h2D};
            7'd13: r = {7'h2B, 7'h3D};
            7'd14: r = {7'h08, 7'h08};
            7'd15: r = {7'h09, 7'h09};
            7'd16: r = {7'h51, 7'h71};
            7'd17: r = {7'h57, 7'h77};
            7'd18: r = {7'h45, 7'h65};
            7'd19: r = {7'h52, 7'h72};
            7'd20: r = {7'h54, 7'h74};
            7'd21: r = {7'h59, 7'h79};
            7'd22: r = {7'h55, 7'h75};
            7'd23: r = {7'h49, 7'h69};
            7'd24: r = {7'h4F, 7'h6F};
            7'd25: r = {7'h50, 7'h70};
            7'd26: r = {7'h7B, 7'h5B};
            7'd27: r = {7'h7D, 7'h5D};
            7'd28: r = {7'h0A, 7'h0A};
            7'd30: r = {7'h41, 7'h61};
            7'd31: r = {7'h53, 7'h73};
            7'd32: r = {7'h44, 7'h64};
            7'd33: r = {7'h46, 7'h66};
            7'd34: r = {7'h47, 7'h67};
            7'd35: r = {7'h48, 7'h68};
            7'd36: r = {7'h4A, 7'h6A};
            7'd37: r = {7'h4B, 7'h6B};
            7'd38: r = {7'h4C, 7'h6C};
            7'd39: r = {7'h3A, 7'h3B};
            7'd40: r = {7'h22, 7'h27};
            7'd41: r = {7'h7E, 7'h60};
            7'd43: r = {7'h7C, 7'h5C};
            7'd44: r = {7'h5A, 7'h7A};
            7'd45: r = {7'h58, 7'h78};
            7'd46: r = {7'h43, 7'h63};
            7'd47: r = {7'h56, 7'h76};
            7'd48: r = {7'h42, 7'h62};
            7'd49: r = {7'h4E, 7'h6E};
            7'd50: r = {7'h4D, 7'h6D};
            7'd51: r = {7'h3C, 7'h2C};
            7'd52: r = {7'h3E, 7'h2E};
            7'd53: r = {7'h3F, 7'h2F};
            7'd55: r = {7'h2A, 7'h2A};
            7'd57: r = {7'h20, 7'h20};
            7'd72: r = {7'h37, 7'h37};
            7'd73: r = {7'h38, 7'h38};
            7'd74: r = {7'h39, 7'h39};
            7'd75: r = {7'h2D, 7'h2D};
            7'd76: r = {7'h34, 7'h34};
            7'd77: r = {7'h35, 7'h35};
            7'd78: r = {7'h36, 7'h36};
            7'd79: r = {7'h2B, 7'h2B};
            7'd80: r = {7'h31, 7'h31};
            7'd81: r = {7'h32, 7'h32};
            7'd82: r = {7'h33, 7'h33};
            7'd83: r = {7'h30, 7'h30};
            7'd84: r = {7'h2E, 7'h2E};
            default: r = 14'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/scancode_to_ascii_fifo.sv =====
`default_nettype none
// A result is poppable once its item has passed the command queue, stage two of the
// back end and the result queue. Throughput: one item per cycle while full is low;
// each item makes at most one access to the character buffer. full rises only once
// the four-entry result queue backs up and the two-entry command queue between
// front and back fills behind it. Reset: synchronous active low; clears enable,
// flags, pointers and queues. The character buffer itself is not cleared.
module scancode_to_ascii_fifo
    import sc2a_pkg::*;
#(
    parameter int BUF_DEPTH = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_scan_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_read_valid,
    output logic [6:0]       o_char_out,
    output logic             o_overflow_dropped,
    output logic [6:0]       o_fill_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;
    localparam int RCW       = $clog2(RES_DEPTH + 1);
    localparam int CCW       = $clog2(CMD_DEPTH + 1);

    logic           r_enable;
    logic           cfg_wr;
    logic           clr;

    logic           cmd_push, cmd_full, cmd_empty, cmd_pop;
    t_cmd           cmd_in, cmd_out;
    logic [CCW-1:0] cmd_count;

    logic           res_push;
    t_res           res_in, res_out;
    logic [RCW-1:0] res_count;
    logic           res_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENABLE);
    assign clr    = cfg_wr && pwdata[0] && !r_enable;
    assign prdata = (paddr[2] == REG_ENABLE) ? {31'd0, r_enable} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (cfg_wr) begin
            r_enable <= pwdata[0];
        end
    end

    sc2a_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (r_enable),
        .i_clr       (clr),
        .i_push      (push),
        .i_req_type  (i_req_type),
        .i_scan_byte (i_scan_byte),
        .i_q_full    (cmd_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    assign full = cmd_full;

    sc2a_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .o_data  (cmd_out),
        .i_pop   (cmd_pop),
        .o_count (cmd_count)
    );

    sc2a_back #(
        .BUF_DEPTH (BUF_DEPTH),
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (clr),
        .i_cmd_valid (!cmd_empty && (cmd_count != '0)),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    sc2a_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push && !res_full),
        .i_data  (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .o_data  (res_out),
        .i_pop   (pop),
        .o_count (res_count)
    );

    assign o_read_valid       = res_out.read_valid;
    assign o_char_out         = res_out.char_out;
    assign o_overflow_dropped = res_out.overflow_dropped;
    assign o_fill_count       = res_out.fill_count;

endmodule
`default_nettype wire

// ===== sv/sc2a_fifo.sv =====
`default_nettype none
module sc2a_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    output logic                            o_full,
    output logic                            o_empty,
    output logic [WIDTH-1:0]                o_data,
    input  wire logic                       i_pop,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/sc2a_front.sv =====
`default_nettype none
module sc2a_front
    import sc2a_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_enable,
    input  wire logic       i_clr,
    input  wire logic       i_push,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_scan_byte,
    input  wire logic       i_q_full,
    output logic            o_cmd_push,
    output t_cmd            o_cmd
);

    logic        r_shift, n_shift;
    logic        r_caps, n_caps;
    logic        accept;
    logic        rel;
    logic [6:0]  code;
    logic [13:0] rom;
    logic [6:0]  ch;

    assign accept = i_push && !i_q_full;
    assign rel    = (i_scan_byte[7] == REL_BIT);
    assign code   = i_scan_byte[6:0];
    assign rom    = key_rom(code);

    always_comb begin
        ch = r_shift ? rom[13:7] : rom[6:0];
        if (r_caps && (ch inside {[7'h61:7'h7A], [7'h41:7'h5A]})) begin
            ch = ch ^ CASE_BIT;
        end
    end

    always_comb begin
        n_shift   = r_shift;
        n_caps    = r_caps;
        o_cmd     = '{kind: K_NOP, ch: 7'd0};
        if (!i_enable) begin
            o_cmd.kind = K_NOP;
        end else if (i_req_type == REQ_READ) begin
            o_cmd.kind = K_READ;
        end else if (code == LSHIFT_CODE || code == RSHIFT_CODE) begin
            n_shift = !rel;
        end else if (!rel && code == CAPS_CODE) begin
            n_caps = !r_caps;
        end else if (!rel && ch != 7'd0) begin
            o_cmd.kind = K_PUSH;
            o_cmd.ch   = ch;
        end
    end

    assign o_cmd_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
        end else if (accept) begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
        end
    end

endmodule
`default_nettype wire

// ===== sv/sc2a_back.sv =====
`default_nettype none
module sc2a_back
    import sc2a_pkg::*;
#(
    parameter int BUF_DEPTH = 128,
    parameter int RES_DEPTH = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clr,
    input  wire logic                          i_cmd_valid,
    input  wire t_cmd                          i_cmd,
    output logic                               o_cmd_pop,
    input  wire logic [$clog2(RES_DEPTH+1)-1:0] i_res_count,
    output logic                               o_res_push,
    output t_res                               o_res
);

    localparam int PTR_W = $clog2(BUF_DEPTH);
    localparam int FW    = (PTR_W + 1 > 7) ? PTR_W + 1 : 7;
    localparam int CW    = $clog2(RES_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(BUF_DEPTH - 1);

    logic [6:0]       r_mem [BUF_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp, wp_nx;
    logic [PTR_W-1:0] r_rp, n_rp, rp_nx;
    logic [6:0]       r_rd_data;
    logic             r_s2_valid;
    logic             r_s2_rv, n_rv;
    logic             r_s2_drop, n_drop;
    logic [6:0]       r_s2_fill, n_fill;
    logic [FW-1:0]    wpe, rpe, fill;
    logic             pop;

    // leave room in the result queue for the item already in stage two
    assign pop = i_cmd_valid &&
                 (({1'b0, i_res_count} + (CW+1)'(r_s2_valid)) < (CW+1)'(RES_DEPTH));
    assign o_cmd_pop = pop;

    assign wp_nx = (r_wp == LAST) ? '0 : r_wp + 1'b1;
    assign rp_nx = (r_rp == LAST) ? '0 : r_rp + 1'b1;

    always_comb begin
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_rv   = 1'b0;
        n_drop = 1'b0;
        if (pop) begin
            case (i_cmd.kind)
                K_READ: begin
                    if (r_wp != r_rp) begin
                        n_rv = 1'b1;
                        n_rp = rp_nx;
                    end
                end
                K_PUSH: begin
                    // full: drop the oldest item
                    if (wp_nx == r_rp) begin
                        n_rp   = rp_nx;
                        n_drop = 1'b1;
                    end
                    n_wp = wp_nx;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        wpe  = FW'(n_wp);
        rpe  = FW'(n_rp);
        fill = (wpe >= rpe) ? wpe - rpe : wpe + FW'(BUF_DEPTH) - rpe;
        n_fill = (fill > FW'(FILL_MAX)) ? FILL_MAX : fill[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_rv   <= n_rv;
        r_s2_drop <= n_drop;
        r_s2_fill <= n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.kind == K_PUSH) begin
            r_mem[r_wp] <= i_cmd.ch;
        end
        if (pop && i_cmd.kind == K_READ) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    assign o_res_push = r_s2_valid;
    always_comb begin
        o_res.read_valid       = r_s2_rv;
        o_res.char_out         = r_s2_rv ? r_rd_data : 7'd0;
        o_res.overflow_dropped = r_s2_drop;
        o_res.fill_count       = r_s2_fill;
    end

endmodule
`default_nettype wire
